### rtl/assert_macros.svh
// Concurrent assertion macros for the double-ended queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/deq_pkg.sv
// Types and codes shared by the double-ended queue RTL.
package deq_pkg;

  // Command codes on opcode
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DUMP_FWD   = 2'd2,
    OP_DUMP_REV   = 2'd3
  } op_t;

  // Result codes on kind
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

endpackage

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values in a ring memory.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------
//  command   | start / busy         | opcode, value
//  result    | strobe (one cycle)   | kind, element, last
//
// A push's single result beat appears the cycle after acceptance, and busy
// stays low, so pushes can be issued every cycle. A dump holds busy high
// while the ring memory is read one entry per cycle; each data beat appears
// in the cycle after its read. A dump of an empty queue answers with a
// single EMPTY beat, like a push.
// rst is synchronous and empties the queue; memory contents are not cleared.
// Result beats cannot be stalled: the receiver must take each strobe.
`include "assert_macros.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         kind,
  output logic signed [31:0] element,
  output logic               last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  // Ring memory
  logic signed [31:0] store [CAPACITY];
  logic signed [31:0] rd_data;

  // Control state
  state_t           state, state_next;
  logic [IDX_W-1:0] front_index, front_index_next;
  logic [CNT_W-1:0] occupancy, occupancy_next;
  logic [IDX_W-1:0] rd_addr, rd_addr_next;
  logic [CNT_W-1:0] remain, remain_next;
  logic             reverse, reverse_next;

  // Result beat registers
  logic             strobe_next;
  kind_t            kind_q, kind_next;
  logic             last_next;
  logic             sel_data, sel_data_next;

  // Memory access controls
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;

  // Slot arithmetic
  logic [SUM_W-1:0] sum_back;
  logic [SUM_W-1:0] sum_tail;
  logic [IDX_W-1:0] back_slot;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] addr_inc;
  logic [IDX_W-1:0] addr_dec;
  logic             full;

  // Wrap the back and tail slots with one compare and subtract
  always_comb begin
    sum_back  = SUM_W'(front_index) + SUM_W'(occupancy);
    sum_tail  = sum_back - SUM_W'(1);
    back_slot = (sum_back >= SUM_W'(CAPACITY)) ?
                IDX_W'(sum_back - SUM_W'(CAPACITY)) : IDX_W'(sum_back);
    tail_slot = (sum_tail >= SUM_W'(CAPACITY)) ?
                IDX_W'(sum_tail - SUM_W'(CAPACITY)) : IDX_W'(sum_tail);
    front_dec = (front_index == '0) ? IDX_W'(CAPACITY - 1) : front_index - IDX_W'(1);
    addr_inc  = (rd_addr == IDX_W'(CAPACITY - 1)) ? '0 : rd_addr + IDX_W'(1);
    addr_dec  = (rd_addr == '0) ? IDX_W'(CAPACITY - 1) : rd_addr - IDX_W'(1);
    full      = (occupancy >= CNT_W'(CAPACITY));
  end

  // Next state, memory controls and result beat
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    occupancy_next   = occupancy;
    rd_addr_next     = rd_addr;
    remain_next      = remain;
    reverse_next     = reverse;
    strobe_next      = 1'b0;
    kind_next        = kind_q;
    last_next        = last;
    sel_data_next    = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = back_slot;
    rd_en            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          case (op_t'(opcode))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                kind_next = KIND_FULL;
              end else begin
                kind_next      = KIND_ACCEPTED;
                wr_en          = 1'b1;
                occupancy_next = occupancy + CNT_W'(1);
                if (op_t'(opcode) == OP_PUSH_FRONT) begin
                  wr_addr          = front_dec;
                  front_index_next = front_dec;
                end
              end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              if (occupancy == '0) begin
                kind_next = KIND_EMPTY;
              end else begin
                // Hold the beat back; data beats come from the read pipe
                strobe_next  = 1'b0;
                state_next   = ST_DUMP;
                remain_next  = occupancy;
                reverse_next = (op_t'(opcode) == OP_DUMP_REV);
                rd_addr_next = (op_t'(opcode) == OP_DUMP_REV) ? tail_slot : front_index;
              end
            end
            default: begin
              kind_next = KIND_EMPTY;
            end
          endcase
        end
      end
      ST_DUMP: begin
        // Read one entry, advance the address, flag the final beat
        rd_en         = 1'b1;
        strobe_next   = 1'b1;
        kind_next     = KIND_DATA;
        sel_data_next = 1'b1;
        last_next     = (remain == CNT_W'(1));
        remain_next   = remain - CNT_W'(1);
        rd_addr_next  = reverse ? addr_dec : addr_inc;
        if (remain == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      occupancy   <= occupancy_next;
      strobe      <= strobe_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    remain   <= remain_next;
    reverse  <= reverse_next;
    kind_q   <= kind_next;
    last     <= last_next;
    sel_data <= sel_data_next;
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= value;
    end
  end

  // Memory read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign busy    = (state == ST_DUMP);
  assign kind    = kind_q;
  assign element = sel_data ? rd_data : '0;

  // Checks
  `ASSERT_CLK(a_occ_bound, clk, rst, occupancy <= CNT_W'(CAPACITY), "occupancy above capacity")
  `ASSERT_CLK(a_strobe_cause, clk, rst, strobe |-> ($past(start && !busy) || $past(state == ST_DUMP)), "result beat without a cause")
  `ASSERT_CLK(a_dump_stable, clk, rst, (state == ST_DUMP) |=> ($stable(occupancy) && $stable(front_index)), "queue changed during dump")
  `ASSERT_CLK(a_single_last, clk, rst, (strobe && (kind_q != KIND_DATA)) |-> last, "status beat not marked last")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the double-ended queue: predicted beats vs. DUT beats.
module tb_top;
  import deq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int ITEMS        = 160;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] element;
    logic               last;
  } beat_t;

  // Track the ring contents and queue the beats each command must produce
  class deque_checker;
    logic signed [31:0] ring [DEPTH];
    int unsigned        head = 0;
    int unsigned        count = 0;
    beat_t              expected_beats[$];
    int                 errors = 0;

    // Apply one accepted command and queue its beats
    function void note_command(op_t op, logic signed [31:0] val);
      beat_t b;
      int unsigned off;
      b.kind    = KIND_ACCEPTED;
      b.element = '0;
      b.last    = 1'b1;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        if (count >= DEPTH) begin
          b.kind = KIND_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = val;
          end else begin
            ring[(head + count) % DEPTH] = val;
          end
          count++;
        end
        expected_beats.push_back(b);
      end else if (count == 0) begin
        b.kind = KIND_EMPTY;
        expected_beats.push_back(b);
      end else begin
        // Walk the occupied slots in the requested direction
        for (int unsigned i = 0; i < count; i++) begin
          off       = (op == OP_DUMP_FWD) ? i : (count - 1 - i);
          b.kind    = KIND_DATA;
          b.element = ring[(head + off) % DEPTH];
          b.last    = (i + 1 == count);
          expected_beats.push_back(b);
        end
      end
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_beat(logic [1:0] k, logic signed [31:0] e, logic l);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat kind %0d element %0d last %0d",
                 $time, k, e, l);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (k !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
        errors++;
      end
      if (e !== want.element) begin
        $display("%0t: element expected %0d actual %0d", $time, want.element, e);
        errors++;
      end
      if (l !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = OP_PUSH_FRONT;
  logic signed [31:0] value = '0;
  logic               strobe;
  logic [1:0]         kind;
  logic signed [31:0] element;
  logic               last;
  int                 cycles = 0;

  deque_checker sb = new;

  double_ended_queue #(.CAPACITY(DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .opcode  (opcode),
    .value   (value),
    .strobe  (strobe),
    .kind    (kind),
    .element (element),
    .last    (last)
  );

  // Generate the clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Note accepted commands, then check any result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_command(op_t'(opcode), value);
      if (strobe) sb.check_beat(kind, element, last);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one command beat, optionally after a random idle gap with noise
  task automatic issue(input op_t op, input logic signed [31:0] val, input int idle_pct);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start  <= 1'b0;
      opcode <= 2'($urandom_range(3, 0));
      value  <= $urandom;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pick a command: mostly pushes, so the queue fills partway through
  function automatic op_t pick_op();
    if ($urandom_range(99, 0) < 65)
      return $urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(1, 0) ? OP_DUMP_REV : OP_DUMP_FWD;
  endfunction

  initial begin
    int idle;
    // Hold reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dumps, front wrap, value extremes, both dump orders
    issue(OP_DUMP_FWD,   32'sd0,        0);
    issue(OP_DUMP_REV,   -32'sd1,       0);
    issue(OP_PUSH_FRONT, 32'h7FFF_FFFF, 0);
    issue(OP_PUSH_FRONT, 32'h8000_0000, 0);
    issue(OP_DUMP_FWD,   32'sd0,        0);
    issue(OP_PUSH_BACK,  32'sd0,        0);
    issue(OP_PUSH_BACK,  -32'sd1,       0);
    issue(OP_PUSH_FRONT, 32'h5555_5555, 0);
    issue(OP_PUSH_BACK,  32'hAAAA_AAAA, 0);
    issue(OP_DUMP_FWD,   32'hFFFF_FFFF, 0);
    issue(OP_DUMP_REV,   32'h0000_0001, 0);
    issue(OP_PUSH_FRONT, 32'sd1,        0);
    issue(OP_DUMP_REV,   32'sd0,        0);

    // Random: no idling, heavy sender idling, light sender idling
    for (int p = 0; p < 3; p++) begin
      idle = (p == 1) ? 83 : (p == 2) ? 30 : 0;
      for (int n = 0; n < ITEMS / 3; n++) issue(pick_op(), $urandom, idle);
    end

    // Hit the full queue and dump it both ways
    while (sb.count < DEPTH) issue(OP_PUSH_BACK, $urandom, 0);
    issue(OP_PUSH_FRONT, $urandom, 0);
    issue(OP_PUSH_BACK,  $urandom, 0);
    issue(OP_DUMP_FWD,   $urandom, 0);
    issue(OP_DUMP_REV,   $urandom, 0);

    // Drain outstanding beats, then watch for stray ones
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
